/* src/mia_pkg.sv */
// ----------------------------------------------------------------------------
// mia_pkg: shared types and constants for the accumulator evaluator
// Function codes, sequencer states, feature layout and score arithmetic
// constants used by the incremental accumulator evaluator.
// ----------------------------------------------------------------------------
package mia_pkg;

    // Feature layout: twelve pieces on 64 squares, then five flag rows.
    localparam int FEATURES   = 773;
    localparam int PIECE_ROWS = 12 * 8 * 8;
    localparam int FLAG_ROWS  = 5;
    localparam int ROW_W      = 10;

    // Function codes carried on the func field.
    localparam logic [2:0] FN_CLEAR = 3'd0;
    localparam logic [2:0] FN_PIECE = 3'd1;
    localparam logic [2:0] FN_MOVE  = 3'd2;
    localparam logic [2:0] FN_FLAG  = 3'd3;
    localparam logic [2:0] FN_EVAL  = 3'd4;
    localparam logic [2:0] FN_WRITE = 3'd5;

    localparam logic [3:0] PIECE_FIRST = 4'd1;
    localparam logic [3:0] PIECE_LAST  = 4'd12;

    // Score arithmetic.
    localparam int FRAC_BITS  = 10;
    localparam int SCORE_BITS = 24;
    localparam int SUM_W      = 74;
    localparam int MAG_W      = 41;
    localparam int SCALE_W    = 7;
    localparam int SCALED_W   = MAG_W + SCALE_W;
    localparam int SHIFTED_W  = SCALED_W - 2 * FRAC_BITS;
    localparam logic [SCALE_W-1:0] SCORE_SCALE = 7'd100;
    localparam logic signed [SUM_W-1:0] SUM_LIMIT = SUM_W'(1) <<< 61;
    localparam logic [MAG_W-1:0] MAG_LIMIT = MAG_W'(1) << 40;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_UPD,
        ST_UDRAIN,
        ST_EVAL,
        ST_EDRAIN,
        ST_BIAS,
        ST_MAG,
        ST_SCORE
    } state_t;

    // Clamp a running sum to plus or minus the internal limit.
    function automatic logic signed [SUM_W-1:0] clamp_sum(
        input logic signed [SUM_W-1:0] x
    );
        logic signed [SUM_W-1:0] r;
        r = x;
        if (x > SUM_LIMIT)
        begin
            r = SUM_LIMIT;
        end
        else if (x < -SUM_LIMIT)
        begin
            r = -SUM_LIMIT;
        end
        return r;
    endfunction

endpackage

/* src/mlp_incremental_accumulator_eval.sv */
// ----------------------------------------------------------------------------
// mlp_incremental_accumulator_eval: incremental two-layer perceptron scorer
// Keeps one first-layer accumulator per hidden neuron and the weight store,
// applies row updates in place and scores the position on request.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one request per handshake,
//   selected by func. Only an evaluate request produces a score on the output
//   channel (out_valid / out_stall); all other requests produce nothing.
//   A weight write completes in the accepting cycle. A change-piece or
//   change-flag request sweeps all neurons through one shared adder; a move
//   runs two such sweeps. A clear writes zero to one accumulator entry per cycle.
//   An evaluate streams every neuron through one multiply-accumulate
//   pipeline of four stages, then through the scaling states BIAS, MAG and
//   SCORE to the output register. in_stall is high while a request is being
//   worked on. After reset the accumulator is cleared by a pass over all
//   neurons during which no request is accepted. A score waits in the output
//   register while the receiver stalls; requests are still accepted meanwhile,
//   but a second evaluate holds in its final stage until the first score is
//   taken.
// ----------------------------------------------------------------------------
module mlp_incremental_accumulator_eval #(
    parameter int NEURONS     = 256,
    parameter int WEIGHT_BITS = 16,
    parameter int ACC_BITS    = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           func,
    input  logic [3:0]                           piece,
    input  logic [5:0]                           square,
    input  logic [5:0]                           new_square,
    input  logic                                 add,
    input  logic [2:0]                           flag_row,
    input  logic                                 side,
    input  logic [17:0]                          weight_addr,
    input  logic signed [15:0]                   weight_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mia_pkg::SCORE_BITS-1:0] score
);

    localparam int NW        = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int CW        = $clog2(NEURONS + 1);
    localparam int L1W_COUNT = mia_pkg::FEATURES * NEURONS;
    localparam int LW        = $clog2(L1W_COUNT);
    localparam int AW0       = $clog2(L1W_COUNT + 2 * NEURONS + 2);
    localparam int EW        = (AW0 > 18) ? AW0 : 18;
    localparam int MAXW      = (ACC_BITS > WEIGHT_BITS) ? ACC_BITS : WEIGHT_BITS;
    localparam int PREW      = MAXW + 2;
    localparam int PW        = ACC_BITS + WEIGHT_BITS;
    localparam logic [CW-1:0] LAST = CW'(NEURONS - 1);
    localparam logic signed [PREW-1:0] ACC_MAX =
        PREW'($signed({1'b0, {(ACC_BITS-1){1'b1}}}));
    localparam logic signed [PREW-1:0] ACC_MIN =
        PREW'($signed({1'b1, {(ACC_BITS-1){1'b0}}}));
    localparam logic [LW-1:0] SIDE_BASE = LW'(mia_pkg::PIECE_ROWS * NEURONS);
    localparam logic signed [mia_pkg::SHIFTED_W:0] SCORE_HI =
        (mia_pkg::SHIFTED_W + 1)'(2 ** (mia_pkg::SCORE_BITS - 1) - 1);
    localparam logic signed [mia_pkg::SHIFTED_W:0] SCORE_LO =
        (mia_pkg::SHIFTED_W + 1)'(-(2 ** (mia_pkg::SCORE_BITS - 1)));

    // Memories.
    logic signed [WEIGHT_BITS-1:0] l1w_mem [L1W_COUNT];
    logic signed [WEIGHT_BITS-1:0] l1b_mem [NEURONS];
    logic signed [WEIGHT_BITS-1:0] l2w_mem [NEURONS];
    logic signed [ACC_BITS-1:0]    acc_mem [NEURONS];

    // Control and datapath registers.
    mia_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]   base_reg, base_next;
    logic [LW-1:0]   base2_reg, base2_next;
    logic            plus_reg, plus_next;
    logic            second_reg, second_next;
    logic            black_reg, black_next;
    logic            v1_reg, v2_reg, v3_reg;
    logic [NW-1:0]   idx1_reg;
    logic signed [WEIGHT_BITS-1:0] l2b_reg;
    logic signed [WEIGHT_BITS-1:0] l1w_rd_reg, l1b_rd_reg, l2w_rd_reg;
    logic signed [ACC_BITS-1:0]    acc_rd_reg;
    logic signed [ACC_BITS-1:0]    relu_reg;
    logic signed [WEIGHT_BITS-1:0] w2_reg;
    logic signed [mia_pkg::SUM_W-1:0] term_reg;
    logic signed [mia_pkg::SUM_W-1:0] sum_reg;
    logic                          neg_reg;
    logic [mia_pkg::MAG_W-1:0]     mag_reg;
    logic                          out_valid_reg;
    logic signed [mia_pkg::SCORE_BITS-1:0] score_reg;

    // Control outputs of the sequencer.
    logic            accept;
    logic            issue;
    logic            eval_issue;
    logic            acc_we;
    logic [NW-1:0]   acc_wa;
    logic signed [ACC_BITS-1:0] acc_wd;
    logic            score_load;

    // Request decode.
    logic            piece_ok;
    logic [mia_pkg::ROW_W-1:0] row_old, row_new, row_flag;
    logic [EW-1:0]   addr_ext, addr_off1, addr_off2;
    logic            wr_l1w, wr_l1b, wr_l2w, wr_l2b;
    logic signed [WEIGHT_BITS-1:0] wv;
    logic [LW-1:0]   l1w_ra;
    logic [NW-1:0]   idx;

    // Datapath combinational values.
    logic signed [PREW-1:0] upd_sum;
    logic signed [PREW-1:0] pre_sum;
    logic signed [ACC_BITS-1:0] pre_sat;
    logic signed [PW-1:0]   prod;
    logic signed [mia_pkg::SUM_W-1:0] biased;
    logic [mia_pkg::SCALED_W-1:0] scaled;
    logic [mia_pkg::SHIFTED_W-1:0] shifted;
    logic signed [mia_pkg::SHIFTED_W:0] signed_score;
    logic            final_neg;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != mia_pkg::ST_IDLE);
    assign piece_ok = (piece >= mia_pkg::PIECE_FIRST) && (piece <= mia_pkg::PIECE_LAST);
    assign row_old  = {piece - 4'd1, square};
    assign row_new  = {piece - 4'd1, new_square};
    assign row_flag = mia_pkg::ROW_W'(mia_pkg::PIECE_ROWS) + mia_pkg::ROW_W'(flag_row);
    assign idx      = cnt_reg[NW-1:0];

    // Weight write address decode.
    assign addr_ext  = EW'(weight_addr);
    assign addr_off1 = addr_ext - EW'(L1W_COUNT);
    assign addr_off2 = addr_off1 - EW'(NEURONS);
    assign wv        = WEIGHT_BITS'(weight_value);
    always_comb
    begin
        wr_l1w = 1'b0;
        wr_l1b = 1'b0;
        wr_l2w = 1'b0;
        wr_l2b = 1'b0;
        if (accept && func == mia_pkg::FN_WRITE)
        begin
            if (addr_ext < EW'(L1W_COUNT))
            begin
                wr_l1w = 1'b1;
            end
            else if (addr_off1 < EW'(NEURONS))
            begin
                wr_l1b = 1'b1;
            end
            else if (addr_off2 < EW'(NEURONS))
            begin
                wr_l2w = 1'b1;
            end
            else if (addr_off2 == EW'(NEURONS))
            begin
                wr_l2b = 1'b1;
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        base_next   = base_reg;
        base2_next  = base2_reg;
        plus_next   = plus_reg;
        second_next = second_reg;
        black_next  = black_reg;
        unique case (state_reg)
            mia_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    unique case (func)
                        mia_pkg::FN_CLEAR:
                        begin
                            state_next = mia_pkg::ST_CLEAR;
                        end
                        mia_pkg::FN_PIECE:
                        begin
                            if (piece_ok)
                            begin
                                state_next  = mia_pkg::ST_UPD;
                                base_next   = LW'(row_old) * LW'(NEURONS);
                                plus_next   = add;
                                second_next = 1'b0;
                            end
                        end
                        mia_pkg::FN_MOVE:
                        begin
                            if (piece_ok)
                            begin
                                state_next  = mia_pkg::ST_UPD;
                                base_next   = LW'(row_old) * LW'(NEURONS);
                                base2_next  = LW'(row_new) * LW'(NEURONS);
                                plus_next   = 1'b0;
                                second_next = 1'b1;
                            end
                        end
                        mia_pkg::FN_FLAG:
                        begin
                            if (flag_row < 3'(mia_pkg::FLAG_ROWS))
                            begin
                                state_next  = mia_pkg::ST_UPD;
                                base_next   = LW'(row_flag) * LW'(NEURONS);
                                plus_next   = add;
                                second_next = 1'b0;
                            end
                        end
                        mia_pkg::FN_EVAL:
                        begin
                            state_next = mia_pkg::ST_EVAL;
                            black_next = side;
                        end
                        default:
                        begin
                            state_next = mia_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mia_pkg::ST_CLEAR:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = mia_pkg::ST_IDLE;
                end
            end
            mia_pkg::ST_UPD:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = mia_pkg::ST_UDRAIN;
                end
            end
            mia_pkg::ST_UDRAIN:
            begin
                cnt_next = '0;
                if (second_reg)
                begin
                    state_next  = mia_pkg::ST_UPD;
                    base_next   = base2_reg;
                    plus_next   = 1'b1;
                    second_next = 1'b0;
                end
                else
                begin
                    state_next = mia_pkg::ST_IDLE;
                end
            end
            mia_pkg::ST_EVAL:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == LAST)
                begin
                    state_next = mia_pkg::ST_EDRAIN;
                end
            end
            mia_pkg::ST_EDRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = mia_pkg::ST_BIAS;
                end
            end
            mia_pkg::ST_BIAS:
            begin
                state_next = mia_pkg::ST_MAG;
            end
            mia_pkg::ST_MAG:
            begin
                state_next = mia_pkg::ST_SCORE;
            end
            mia_pkg::ST_SCORE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = mia_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mia_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        issue      = 1'b0;
        eval_issue = 1'b0;
        score_load = 1'b0;
        acc_we     = 1'b0;
        acc_wa     = idx1_reg;
        acc_wd     = pre_sat;
        unique case (state_reg)
            mia_pkg::ST_CLEAR:
            begin
                acc_we = 1'b1;
                acc_wa = idx;
                acc_wd = '0;
            end
            mia_pkg::ST_UPD, mia_pkg::ST_UDRAIN:
            begin
                issue  = (state_reg == mia_pkg::ST_UPD);
                acc_we = v1_reg;
                if (upd_sum > ACC_MAX)
                begin
                    acc_wd = ACC_MAX[ACC_BITS-1:0];
                end
                else if (upd_sum < ACC_MIN)
                begin
                    acc_wd = ACC_MIN[ACC_BITS-1:0];
                end
                else
                begin
                    acc_wd = upd_sum[ACC_BITS-1:0];
                end
            end
            mia_pkg::ST_EVAL:
            begin
                eval_issue = 1'b1;
            end
            mia_pkg::ST_SCORE:
            begin
                score_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // Weight store read address: the row being swept, or the side row.
    assign l1w_ra = eval_issue ? (SIDE_BASE + LW'(idx)) : (base_reg + LW'(idx));

    // Row update arithmetic.
    assign upd_sum = plus_reg ? (PREW'(acc_rd_reg) + PREW'(l1w_rd_reg))
                              : (PREW'(acc_rd_reg) - PREW'(l1w_rd_reg));

    // Evaluate stage two: bias and side row, saturated.
    assign pre_sum = PREW'(acc_rd_reg) + PREW'(l1b_rd_reg)
                   + (black_reg ? PREW'(0) : PREW'(l1w_rd_reg));
    always_comb
    begin
        if (pre_sum > ACC_MAX)
        begin
            pre_sat = ACC_MAX[ACC_BITS-1:0];
        end
        else if (pre_sum < ACC_MIN)
        begin
            pre_sat = ACC_MIN[ACC_BITS-1:0];
        end
        else
        begin
            pre_sat = pre_sum[ACC_BITS-1:0];
        end
    end

    // Evaluate stage three: one multiplier.
    assign prod = PW'(relu_reg) * PW'(w2_reg);

    // Final scaling.
    assign biased  = mia_pkg::clamp_sum(sum_reg + (mia_pkg::SUM_W'(l2b_reg)
                                         <<< mia_pkg::FRAC_BITS));
    assign scaled  = mia_pkg::SCALED_W'(mag_reg) * mia_pkg::SCALED_W'(mia_pkg::SCORE_SCALE);
    assign shifted = scaled[mia_pkg::SCALED_W-1:2*mia_pkg::FRAC_BITS];
    assign final_neg = neg_reg ^ black_reg;
    assign signed_score = final_neg ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (wr_l1w)
        begin
            l1w_mem[addr_ext[LW-1:0]] <= wv;
        end
        if (wr_l1b)
        begin
            l1b_mem[addr_off1[NW-1:0]] <= wv;
        end
        if (wr_l2w)
        begin
            l2w_mem[addr_off2[NW-1:0]] <= wv;
        end
        if (wr_l2b)
        begin
            l2b_reg <= wv;
        end
        if (acc_we)
        begin
            acc_mem[acc_wa] <= acc_wd;
        end
        l1w_rd_reg <= l1w_mem[l1w_ra];
        l1b_rd_reg <= l1b_mem[idx];
        l2w_rd_reg <= l2w_mem[idx];
        acc_rd_reg <= acc_mem[idx];
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        idx1_reg <= idx;
        relu_reg <= (pre_sat > 0) ? pre_sat : '0;
        w2_reg   <= l2w_rd_reg;
        term_reg <= mia_pkg::clamp_sum(mia_pkg::SUM_W'(prod));
        base_reg   <= base_next;
        base2_reg  <= base2_next;
        plus_reg   <= plus_next;
        second_reg <= second_next;
        black_reg  <= black_next;
        if (state_reg == mia_pkg::ST_IDLE)
        begin
            sum_reg <= '0;
        end
        else if (v3_reg)
        begin
            sum_reg <= mia_pkg::clamp_sum(sum_reg + term_reg);
        end
        else if (state_reg == mia_pkg::ST_BIAS)
        begin
            sum_reg <= biased;
        end
        if (state_reg == mia_pkg::ST_MAG)
        begin
            neg_reg <= sum_reg < 0;
            if ((sum_reg < 0 ? -sum_reg : sum_reg) > mia_pkg::SUM_W'(mia_pkg::MAG_LIMIT))
            begin
                mag_reg <= mia_pkg::MAG_LIMIT;
            end
            else
            begin
                mag_reg <= mia_pkg::MAG_W'(sum_reg < 0 ? -sum_reg : sum_reg);
            end
        end
        if (score_load)
        begin
            if (signed_score > SCORE_HI)
            begin
                score_reg <= SCORE_HI[mia_pkg::SCORE_BITS-1:0];
            end
            else if (signed_score < SCORE_LO)
            begin
                score_reg <= SCORE_LO[mia_pkg::SCORE_BITS-1:0];
            end
            else
            begin
                score_reg <= signed_score[mia_pkg::SCORE_BITS-1:0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mia_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= issue || eval_issue;
            v2_reg    <= v1_reg && (state_reg == mia_pkg::ST_EVAL
                                    || state_reg == mia_pkg::ST_EDRAIN);
            v3_reg    <= v2_reg;
            if (score_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign score     = score_reg;

    // A score appears only from the final scaling state.
    a_score_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == mia_pkg::ST_SCORE)
        else $error("score raised outside the scaling state");

    // The neuron counter never runs past the neuron count.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(NEURONS))
        else $error("neuron counter out of range");

    // An accepted evaluate starts the sweep in the next cycle.
    a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func == mia_pkg::FN_EVAL |=> state_reg == mia_pkg::ST_EVAL)
        else $error("evaluate did not start");

    // The accumulator is written only by a clear or an update sweep.
    a_acc_write: assert property (@(posedge clk) disable iff (!rst_n)
        acc_we |-> (state_reg == mia_pkg::ST_CLEAR || state_reg == mia_pkg::ST_UPD
                    || state_reg == mia_pkg::ST_UDRAIN))
        else $error("accumulator written outside a sweep");

endmodule

/* test/mlp_incremental_accumulator_eval_test.sv */
// ----------------------------------------------------------------------------
// mlp_incremental_accumulator_eval_test: self-checking bench for the scorer
// Loads the weights for a chosen set of feature rows, then runs directed and
// random accumulator updates and evaluations. Each score is checked against
// a bit-exact prediction of the accumulator and the scoring arithmetic.
// ----------------------------------------------------------------------------
module mlp_incremental_accumulator_eval_test;

    localparam int NEURONS    = 256;
    localparam int L1W_COUNT  = mia_pkg::FEATURES * NEURONS;
    localparam int BIAS_BASE  = L1W_COUNT;
    localparam int W2_BASE    = L1W_COUNT + NEURONS;
    localparam int B2_ADDR    = L1W_COUNT + 2 * NEURONS;
    localparam int WATCHDOG   = 20000;
    localparam int HOLD_LEN   = 3000;

    typedef struct {
        logic [2:0]         func;
        logic [3:0]         piece;
        logic [5:0]         square;
        logic [5:0]         new_square;
        logic               add;
        logic [2:0]         flag_row;
        logic               side;
        logic [17:0]        weight_addr;
        logic signed [15:0] weight_value;
    } request_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [2:0] func;
    logic [3:0] piece;
    logic [5:0] square;
    logic [5:0] new_square;
    logic add;
    logic [2:0] flag_row;
    logic side;
    logic [17:0] weight_addr;
    logic signed [15:0] weight_value;
    logic out_valid;
    logic out_stall;
    logic signed [mia_pkg::SCORE_BITS-1:0] score;

    // Shadow copy of the block's state.
    logic signed [15:0] row_weights [0:L1W_COUNT-1];
    logic signed [15:0] hidden_bias [0:NEURONS-1];
    logic signed [15:0] out_weights [0:NEURONS-1];
    logic signed [15:0] out_bias;
    longint             acc_shadow [0:NEURONS-1];

    request_t                              pending_requests [$];
    logic signed [mia_pkg::SCORE_BITS-1:0] score_queue [$];

    // Squares whose piece rows are loaded; stimulus reads only these rows.
    int loaded_squares [4] = '{0, 63, 21, 42};

    bit took_request;
    int send_gap;
    int quiet_left;
    int recv_gap;
    int hold_left;
    bit hold_done;
    int accepted_count;
    int idle_cycles;
    bit failed;

    mlp_incremental_accumulator_eval dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .piece        (piece),
        .square       (square),
        .new_square   (new_square),
        .add          (add),
        .flag_row     (flag_row),
        .side         (side),
        .weight_addr  (weight_addr),
        .weight_value (weight_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .score        (score)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic longint saturate_to(longint x, int bits);
        longint lim;
        lim = longint'(1) <<< (bits - 1);
        if (x < -lim)
        begin
            return -lim;
        end
        if (x > lim - 1)
        begin
            return lim - 1;
        end
        return x;
    endfunction

    function automatic longint clamp_total(longint x);
        longint lim;
        lim = longint'(1) <<< 61;
        if (x > lim)
        begin
            return lim;
        end
        if (x < -lim)
        begin
            return -lim;
        end
        return x;
    endfunction

    // Add or subtract one weight row across all neurons.
    task automatic sweep_row(int row, bit plus);
        longint w;
        for (int n = 0; n < NEURONS; n++)
        begin
            w = row_weights[row * NEURONS + n];
            acc_shadow[n] = saturate_to(plus ? acc_shadow[n] + w : acc_shadow[n] - w, 24);
        end
    endtask

    // Score of the current accumulator, relative to the side to move.
    function automatic logic signed [mia_pkg::SCORE_BITS-1:0] position_score(bit black);
        longint total;
        longint pre;
        longint w2;
        longint mag;
        bit neg;
        total = 0;
        for (int n = 0; n < NEURONS; n++)
        begin
            pre = acc_shadow[n] + hidden_bias[n];
            if (!black)
            begin
                pre += row_weights[mia_pkg::PIECE_ROWS * NEURONS + n];
            end
            pre = saturate_to(pre, 24);
            if (pre > 0)
            begin
                w2 = out_weights[n];
                total = clamp_total(total + pre * w2);
            end
        end
        total = clamp_total(total + longint'(out_bias) * 1024);
        neg = total < 0;
        mag = neg ? -total : total;
        if (mag > (longint'(1) <<< 40))
        begin
            mag = longint'(1) <<< 40;
        end
        mag = (mag * 100) >>> 20;
        if (black)
        begin
            neg = !neg;
        end
        return mia_pkg::SCORE_BITS'(saturate_to(neg ? -mag : mag, mia_pkg::SCORE_BITS));
    endfunction

    // Apply one accepted request to the shadow state.
    task automatic predict_request(request_t r);
        int a;
        bit piece_ok;
        piece_ok = r.piece >= mia_pkg::PIECE_FIRST && r.piece <= mia_pkg::PIECE_LAST;
        case (r.func)
            mia_pkg::FN_CLEAR:
            begin
                for (int n = 0; n < NEURONS; n++)
                begin
                    acc_shadow[n] = 0;
                end
            end
            mia_pkg::FN_PIECE:
            begin
                if (piece_ok)
                begin
                    sweep_row((r.piece - 1) * 64 + r.square, r.add);
                end
            end
            mia_pkg::FN_MOVE:
            begin
                if (piece_ok)
                begin
                    sweep_row((r.piece - 1) * 64 + r.square, 1'b0);
                    sweep_row((r.piece - 1) * 64 + r.new_square, 1'b1);
                end
            end
            mia_pkg::FN_FLAG:
            begin
                if (r.flag_row < mia_pkg::FLAG_ROWS)
                begin
                    sweep_row(mia_pkg::PIECE_ROWS + r.flag_row, r.add);
                end
            end
            mia_pkg::FN_EVAL:
            begin
                score_queue.push_back(position_score(r.side));
            end
            mia_pkg::FN_WRITE:
            begin
                a = r.weight_addr;
                if (a < L1W_COUNT)
                begin
                    row_weights[a] = r.weight_value;
                end
                else if (a < W2_BASE)
                begin
                    hidden_bias[a - BIAS_BASE] = r.weight_value;
                end
                else if (a < B2_ADDR)
                begin
                    out_weights[a - W2_BASE] = r.weight_value;
                end
                else if (a == B2_ADDR)
                begin
                    out_bias = r.weight_value;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Request with random don't-care fields, so every bit moves.
    function automatic request_t noise_request(logic [2:0] f);
        request_t r;
        r.func         = f;
        r.piece        = 4'($urandom);
        r.square       = 6'($urandom);
        r.new_square   = 6'($urandom);
        r.add          = 1'($urandom);
        r.flag_row     = 3'($urandom);
        r.side         = 1'($urandom);
        r.weight_addr  = 18'($urandom_range(B2_ADDR + 1, 262143));
        r.weight_value = 16'($urandom);
        return r;
    endfunction

    task automatic queue_write(int a, int v);
        request_t r;
        r = noise_request(mia_pkg::FN_WRITE);
        r.weight_addr  = 18'(a);
        r.weight_value = 16'(v);
        pending_requests.push_back(r);
    endtask

    task automatic queue_piece(int pc, int sq, bit plus);
        request_t r;
        r = noise_request(mia_pkg::FN_PIECE);
        r.piece  = 4'(pc);
        r.square = 6'(sq);
        r.add    = plus;
        pending_requests.push_back(r);
    endtask

    task automatic queue_move(int pc, int from_sq, int to_sq);
        request_t r;
        r = noise_request(mia_pkg::FN_MOVE);
        r.piece      = 4'(pc);
        r.square     = 6'(from_sq);
        r.new_square = 6'(to_sq);
        pending_requests.push_back(r);
    endtask

    task automatic queue_flag(int fr, bit plus);
        request_t r;
        r = noise_request(mia_pkg::FN_FLAG);
        r.flag_row = 3'(fr);
        r.add      = plus;
        pending_requests.push_back(r);
    endtask

    task automatic queue_eval(bit black);
        request_t r;
        r = noise_request(mia_pkg::FN_EVAL);
        r.side = black;
        pending_requests.push_back(r);
    endtask

    // Load the rows and tables that the stimulus will read.
    task automatic load_weights();
        int row;
        for (int pc = 1; pc <= 12; pc++)
        begin
            foreach (loaded_squares[i])
            begin
                row = (pc - 1) * 64 + loaded_squares[i];
                for (int n = 0; n < NEURONS; n++)
                begin
                    if (row == 0)
                    begin
                        queue_write(row * NEURONS + n, 32767);
                    end
                    else if (row == mia_pkg::PIECE_ROWS - 1)
                    begin
                        queue_write(row * NEURONS + n, -32768);
                    end
                    else
                    begin
                        queue_write(row * NEURONS + n, $signed(16'($urandom)));
                    end
                end
            end
        end
        for (int k = mia_pkg::PIECE_ROWS * NEURONS; k <= B2_ADDR; k++)
        begin
            if (k >= W2_BASE && k < B2_ADDR && $urandom_range(0, 1))
            begin
                queue_write(k, 32767);
            end
            else
            begin
                queue_write(k, $signed(16'($urandom)));
            end
        end
    endtask

    // Stimulus.
    initial
    begin
        int pc;
        int choice;
        load_weights();

        // Directed: extremes of piece and square, all operations, ignored codes.
        queue_eval(1'b0);
        queue_eval(1'b1);
        queue_piece(1, 0, 1'b1);
        queue_piece(12, 63, 1'b1);
        queue_piece(8, 42, 1'b0);
        queue_move(1, 0, 63);
        queue_move(12, 63, 21);
        queue_flag(0, 1'b1);
        queue_flag(4, 1'b0);
        queue_flag(2, 1'b1);
        queue_eval(1'b0);
        queue_eval(1'b1);
        queue_piece(0, 0, 1'b1);
        queue_piece(13, 63, 1'b1);
        queue_move(15, 21, 42);
        queue_flag(5, 1'b1);
        queue_flag(7, 1'b0);
        pending_requests.push_back(noise_request(3'd6));
        pending_requests.push_back(noise_request(3'd7));
        queue_write(262143, -1);
        queue_write(B2_ADDR + 1, 12345);
        queue_eval(1'b0);
        queue_write(B2_ADDR, -32768);
        queue_eval(1'b1);
        queue_piece(0, 0, 1'b0);
        pending_requests.push_back(noise_request(mia_pkg::FN_CLEAR));
        queue_eval(1'b0);

        // Random: position-like sequences, with saturation runs and noise.
        for (int i = 0; i < 800; i++)
        begin
            choice = $urandom_range(0, 99);
            if (i == 200 || i == 500)
            begin
                // Drive the accumulator into saturation and back.
                for (int k = 0; k < 270; k++)
                begin
                    queue_piece(1, 0, i == 200);
                end
                queue_eval(1'b0);
                queue_eval(1'b1);
                queue_move(1, 0, 0);
                queue_eval(1'b0);
            end
            pc = $urandom_range(1, 12);
            if (choice < 30)
            begin
                queue_piece(pc, loaded_squares[$urandom_range(0, 3)], 1'($urandom));
            end
            else if (choice < 45)
            begin
                queue_move(pc, loaded_squares[$urandom_range(0, 3)],
                           loaded_squares[$urandom_range(0, 3)]);
            end
            else if (choice < 55)
            begin
                queue_flag($urandom_range(0, 4), 1'($urandom));
            end
            else if (choice < 80)
            begin
                queue_eval(1'($urandom));
            end
            else if (choice < 88)
            begin
                if ($urandom_range(0, 1))
                begin
                    queue_write($urandom_range(mia_pkg::PIECE_ROWS * NEURONS, B2_ADDR),
                                $signed(16'($urandom)));
                end
                else
                begin
                    queue_write($urandom_range(0, 262143), $signed(16'($urandom)));
                end
            end
            else if (choice < 90)
            begin
                pending_requests.push_back(noise_request(mia_pkg::FN_CLEAR));
            end
            else if (choice < 95)
            begin
                queue_piece($urandom_range(0, 1) ? 0 : $urandom_range(13, 15),
                            $urandom_range(0, 63), 1'($urandom));
            end
            else
            begin
                pending_requests.push_back(noise_request(3'($urandom_range(6, 7))));
            end
        end
    end

    function automatic int random_gap();
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 80);
        end
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Request driver.
    always @(negedge clk or negedge rst_n)
    begin
        request_t r;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            func         <= mia_pkg::FN_CLEAR;
            piece        <= '0;
            square       <= '0;
            new_square   <= '0;
            add          <= 1'b0;
            flag_row     <= '0;
            side         <= 1'b0;
            weight_addr  <= '0;
            weight_value <= '0;
            send_gap     <= 0;
        end
        else if (!in_valid || took_request)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_requests.size() > 0)
            begin
                r = pending_requests.pop_front();
                in_valid     <= 1'b1;
                func         <= r.func;
                piece        <= r.piece;
                square       <= r.square;
                new_square   <= r.new_square;
                add          <= r.add;
                flag_row     <= r.flag_row;
                side         <= r.side;
                weight_addr  <= r.weight_addr;
                weight_value <= r.weight_value;
                send_gap     <= random_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Score receiver stall, with one long hold while requests keep coming.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_count >= 14500)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (recv_gap > 0)
        begin
            out_stall <= 1'b1;
            recv_gap  <= recv_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
            begin
                recv_gap <= random_gap();
            end
        end
    end

    // Accept requests into the prediction and check scores.
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [mia_pkg::SCORE_BITS-1:0] want;
        request_t r;
        if (!rst_n)
        begin
            took_request   <= 1'b0;
            accepted_count <= 0;
            idle_cycles    <= 0;
        end
        else
        begin
            took_request <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                r.func         = func;
                r.piece        = piece;
                r.square       = square;
                r.new_square   = new_square;
                r.add          = add;
                r.flag_row     = flag_row;
                r.side         = side;
                r.weight_addr  = weight_addr;
                r.weight_value = weight_value;
                predict_request(r);
                accepted_count <= accepted_count + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (score_queue.size() == 0)
                begin
                    $error("score %0d arrived with none expected", score);
                    failed = 1'b1;
                end
                else
                begin
                    want = score_queue.pop_front();
                    if (score !== want)
                    begin
                        $error("score mismatch: expected %0d, got %0d", want, score);
                        failed = 1'b1;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG)
            begin
                $display("mlp_incremental_accumulator_eval test failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Reset, wait for drain, report.
    initial
    begin
        failed = 1'b0;
        quiet_left = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        wait (pending_requests.size() == 0 && !in_valid && score_queue.size() == 0);
        repeat (600) @(posedge clk);
        if (score_queue.size() != 0)
        begin
            $error("%0d scores never arrived", score_queue.size());
            failed = 1'b1;
        end
        if (!failed)
        begin
            $display("mlp_incremental_accumulator_eval test passed");
        end
        else
        begin
            $display("mlp_incremental_accumulator_eval test failed");
        end
        $finish;
    end

endmodule
